### hw/rtl/zsc_pkg.sv
// shared constants, types and sequencer states for the zero-sum subarray counter
package zsc_pkg;

  localparam int VALUE_W            = 11;
  localparam int COUNT_W            = 30;
  localparam int SUM_OFFSET_DEFAULT = 1024;

  localparam logic [COUNT_W-1:0] WAYS_MOD = COUNT_W'(1000000007);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } zsc_state_t;

  // per-entry flags that travel with a read request through the update pipeline
  typedef struct packed {
    logic valid;
    logic lo_ok;
    logic hi_ok;
    logic lo_cen;
    logic hi_cen;
    logic cen;
    logic fresh;
  } zsc_req_t;

endpackage

### hw/rtl/zsc_ram.sv
// count store bank: one write port, two read ports with registered read data
module zsc_ram
  import zsc_pkg::*;
#(
  parameter int DEPTH  = 2 * SUM_OFFSET_DEFAULT + 1,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [ADDR_W-1:0]  wr_addr,
  input  logic [COUNT_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]  rd_addr_a,
  input  logic [ADDR_W-1:0]  rd_addr_b,
  output logic [COUNT_W-1:0] rd_data_a,
  output logic [COUNT_W-1:0] rd_data_b
);

  logic [COUNT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

### hw/rtl/zsc_update.sv
// two-stage modular update: sums the two old counts, writes the new count, keeps the total
module zsc_update
  import zsc_pkg::*;
#(
  parameter int ADDR_W = $clog2(2 * SUM_OFFSET_DEFAULT + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  zsc_req_t           req,
  input  logic [ADDR_W-1:0]  req_addr,
  input  logic [COUNT_W-1:0] rd_lo,
  input  logic [COUNT_W-1:0] rd_hi,
  input  logic               total_clr,
  output logic               wr_en,
  output logic [ADDR_W-1:0]  wr_addr,
  output logic [COUNT_W-1:0] wr_data,
  output logic [COUNT_W-1:0] total,
  output logic               busy
);

  function automatic logic [COUNT_W-1:0] mod_add(input logic [COUNT_W-1:0] a,
                                                 input logic [COUNT_W-1:0] b);
    logic [COUNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, WAYS_MOD}) begin
      s = s - {1'b0, WAYS_MOD};
    end
    return s[COUNT_W-1:0];
  endfunction

  zsc_req_t           req1, req2;
  logic [ADDR_W-1:0]  addr1, addr2;
  logic [COUNT_W-1:0] sum2;
  logic [COUNT_W-1:0] opnd_lo, opnd_hi;
  logic [COUNT_W-1:0] cen_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      req1.valid <= 1'b0;
      req2.valid <= 1'b0;
    end else begin
      req1.valid <= req.valid;
      req2.valid <= req1.valid;
    end
    req1.lo_ok  <= req.lo_ok;
    req1.hi_ok  <= req.hi_ok;
    req1.lo_cen <= req.lo_cen;
    req1.hi_cen <= req.hi_cen;
    req1.cen    <= req.cen;
    req1.fresh  <= req.fresh;
    addr1       <= req_addr;
    req2.lo_ok  <= req1.lo_ok;
    req2.hi_ok  <= req1.hi_ok;
    req2.lo_cen <= req1.lo_cen;
    req2.hi_cen <= req1.hi_cen;
    req2.cen    <= req1.cen;
    req2.fresh  <= req1.fresh;
    addr2       <= addr1;
    sum2        <= mod_add(opnd_lo, opnd_hi);
  end

  // a fresh store reads as one at the centre and zero elsewhere
  always_comb begin
    if (!req1.lo_ok) begin
      opnd_lo = '0;
    end else if (req1.fresh) begin
      opnd_lo = COUNT_W'(req1.lo_cen);
    end else begin
      opnd_lo = rd_lo;
    end
    if (!req1.hi_ok) begin
      opnd_hi = '0;
    end else if (req1.fresh) begin
      opnd_hi = COUNT_W'(req1.hi_cen);
    end else begin
      opnd_hi = rd_hi;
    end
  end

  assign cen_inc = mod_add(sum2, COUNT_W'(1));

  assign wr_en   = req2.valid;
  assign wr_addr = addr2;
  assign wr_data = req2.cen ? cen_inc : sum2;
  assign busy    = req1.valid | req2.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (total_clr) begin
      total <= '0;
    end else if (req2.valid && req2.cen) begin
      total <= mod_add(total, sum2);
    end
  end

endmodule

### hw/rtl/zero_signed_sum_subarray_count.sv
// top level: sequencer over two ping-pong count banks and the modular update pipeline
//
// Each input transaction rewrites all 2*SUM_OFFSET+1 counts, one entry per cycle: the
// sequencer reads old[s-v] and old[s+v] from the old bank through its two read ports and
// the update pipeline registers their sum and writes new[s] into the other bank. Before the
// next ready, an item goes through the one-entry-per-cycle sweep, the two-stage pipeline
// drain, the hand-over of the total to the output register and then the idle state with
// ready high; the banks swap roles after every item. The result is held in an output
// register, so the sweep of the next item waits only if the previous result has still
// not been taken when it finishes. Reset and start_req need no clearing pass: the old
// bank is then read as one at the centre and zero elsewhere until the next sweep has
// rewritten every entry.
module zero_signed_sum_subarray_count
  import zsc_pkg::*;
#(
  parameter int SUM_OFFSET = SUM_OFFSET_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [10:0] value, [15:11] zero
  input  logic [0:0]  s_tuser,   // [0] start_req
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [29:0] running_total, [31:30] zero
);

  localparam int WINDOW = 2 * SUM_OFFSET + 1;
  localparam int ADDR_W = $clog2(WINDOW);
  localparam int CALC_W = ((ADDR_W > VALUE_W) ? ADDR_W : VALUE_W) + 1;

  localparam logic [ADDR_W-1:0] CENTRE   = ADDR_W'(SUM_OFFSET);
  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(WINDOW - 1);
  localparam logic [CALC_W-1:0] WIN_EXT  = CALC_W'(WINDOW);

  zsc_state_t state, state_next;

  logic               in_acc;
  logic               finish;
  logic               upd_busy;
  logic [VALUE_W-1:0] value;
  logic [ADDR_W-1:0]  idx;
  logic               fresh;
  logic               sel;
  logic [COUNT_W-1:0] out_total;

  logic [CALC_W-1:0]  idx_ext, value_ext, lo_diff, hi_sum;
  logic [ADDR_W-1:0]  lo_addr, hi_addr;
  zsc_req_t           req;

  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [COUNT_W-1:0] wr_data;
  logic [COUNT_W-1:0] rd0_lo, rd0_hi, rd1_lo, rd1_hi;
  logic [COUNT_W-1:0] rd_lo, rd_hi;
  logic [COUNT_W-1:0] total;

  assign in_acc = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_acc) state_next = ST_RUN;
      ST_RUN:   if (idx == LAST_IDX) state_next = ST_DRAIN;
      ST_DRAIN: if (finish) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    finish   = 1'b0;
    unique case (state)
      ST_IDLE:  s_tready = 1'b1;
      ST_RUN:   s_tready = 1'b0;
      ST_DRAIN: finish = !upd_busy && (!m_tvalid || m_tready);
      default:  s_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      fresh    <= 1'b1;
      sel      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_acc) begin
        fresh <= fresh | s_tuser[0];
      end else if (finish) begin
        fresh <= 1'b0;
        sel   <= ~sel;
      end
      if (finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      value <= s_tdata[VALUE_W-1:0];
      idx   <= '0;
    end else if (state == ST_RUN) begin
      idx <= idx + ADDR_W'(1);
    end
    if (finish) begin
      out_total <= total;
    end
  end

  assign m_tdata = {2'b00, out_total};

  // source addresses of entry idx, with window checks
  assign idx_ext   = CALC_W'(idx);
  assign value_ext = CALC_W'(value);
  assign lo_diff   = idx_ext - value_ext;
  assign hi_sum    = idx_ext + value_ext;
  assign lo_addr   = lo_diff[ADDR_W-1:0];
  assign hi_addr   = hi_sum[ADDR_W-1:0];

  always_comb begin
    req.valid  = (state == ST_RUN);
    req.lo_ok  = (idx_ext >= value_ext);
    req.hi_ok  = (hi_sum < WIN_EXT);
    req.lo_cen = (lo_addr == CENTRE);
    req.hi_cen = (hi_addr == CENTRE);
    req.cen    = (idx == CENTRE);
    req.fresh  = fresh;
  end

  // bank sel is the old bank; the other one takes the writes
  zsc_ram #(
    .DEPTH  (WINDOW),
    .ADDR_W (ADDR_W)
  ) u_bank0 (
    .clk       (clk),
    .wr_en     (wr_en && sel),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (lo_addr),
    .rd_addr_b (hi_addr),
    .rd_data_a (rd0_lo),
    .rd_data_b (rd0_hi)
  );

  zsc_ram #(
    .DEPTH  (WINDOW),
    .ADDR_W (ADDR_W)
  ) u_bank1 (
    .clk       (clk),
    .wr_en     (wr_en && !sel),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (lo_addr),
    .rd_addr_b (hi_addr),
    .rd_data_a (rd1_lo),
    .rd_data_b (rd1_hi)
  );

  assign rd_lo = sel ? rd1_lo : rd0_lo;
  assign rd_hi = sel ? rd1_hi : rd0_hi;

  zsc_update #(
    .ADDR_W (ADDR_W)
  ) u_update (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_addr  (idx),
    .rd_lo     (rd_lo),
    .rd_hi     (rd_hi),
    .total_clr (in_acc && s_tuser[0]),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .total     (total),
    .busy      (upd_busy)
  );

endmodule

### hw/rtl/zsc_checker.sv
// port-level checks on the zero-sum subarray counter, bound to the top level
module zsc_checker
  import zsc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // the total is always reduced
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[29:0] < WAYS_MOD) && (m_tdata[31:30] == 2'b00))
    else $error("running total out of range");

  // one item at a time: the sweep starts right after a transaction
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken during a sweep");

  // a result cannot appear in the cycle after a transaction
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !$rose(m_tvalid))
    else $error("result appeared before the sweep finished");

  a_reset_out: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind zero_signed_sum_subarray_count zsc_checker u_zsc_checker (.*);
